// File: design/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, opcodes and defaults for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  typedef logic [1:0]        opcode_t;
  typedef logic signed [31:0] data_t;
  typedef logic [4:0]        count_t;

  localparam opcode_t OP_PUSH_FRONT = 2'd0;
  localparam opcode_t OP_PUSH_BACK  = 2'd1;
  localparam opcode_t OP_POP_FRONT  = 2'd2;
  localparam opcode_t OP_POP_BACK   = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: design/deq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for operation beats and result beats
// ----------------------------------------------------------------------------
interface deq_in_if;
  import deq_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  data_t   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic   valid;
  logic   ready;
  logic   ok;
  data_t  popped_value;
  count_t count;

  modport source (output valid, output ok, output popped_value, output count, input ready);
  modport sink   (input valid, input ok, input popped_value, input count, output ready);
endinterface
`default_nettype wire

// File: design/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: capture an operation, access the slot store, load the result
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output deq_pkg::dp_cmd_t       cmd
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load_ok   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (load_ok) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/deq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_dp
// Slot store, front index, count and result registers
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire deq_pkg::dp_cmd_t  cmd,
  input  wire deq_pkg::opcode_t  in_opcode,
  input  wire deq_pkg::data_t    in_value,
  output logic                   out_ok,
  output deq_pkg::data_t         out_popped_value,
  output deq_pkg::count_t        out_count
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  data_t mem [DEPTH];

  opcode_t          op_r;
  data_t            val_r;
  data_t            rd_r;
  logic             ok_r;
  logic             pop_ok_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_ok_r;
  data_t            out_pop_r;
  count_t           out_cnt_r;

  logic             is_push, ok, we, re;
  logic [IDX_W-1:0] front_dec, front_inc, back_idx, addr;
  logic [SUM_W-1:0] back_sum;

  assign is_push  = (op_r == OP_PUSH_FRONT) || (op_r == OP_PUSH_BACK);
  assign ok       = is_push ? (cnt_r != CNT_FULL) : (cnt_r != '0);
  assign we       = cmd.exec && ok && is_push;
  assign re       = cmd.exec && ok && !is_push;

  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;

  always_comb begin
    back_sum = SUM_W'(front_r) + SUM_W'(cnt_r);
    if (!is_push) begin
      back_sum = back_sum - 1'b1;
    end
    if (back_sum >= SUM_DEPTH) begin
      back_sum = back_sum - SUM_DEPTH;
    end
    back_idx = back_sum[IDX_W-1:0];
  end

  always_comb begin
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    addr      = back_idx;
    unique case (op_r)
      OP_PUSH_FRONT: begin
        addr = front_dec;
        if (ok) begin
          front_nxt = front_dec;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (ok) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        addr = front_r;
        if (ok) begin
          front_nxt = front_inc;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (ok) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        addr = back_idx;
      end
    endcase
    if (!cmd.exec) begin
      front_nxt = front_r;
      cnt_nxt   = cnt_r;
    end
  end

  // single-port slot store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= val_r;
    end
    if (re) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      ok_r     <= ok;
      pop_ok_r <= ok && !is_push;
    end
    if (cmd.load) begin
      out_ok_r  <= ok_r;
      out_pop_r <= pop_ok_r ? rd_r : '0;
      out_cnt_r <= count_t'(cnt_r);
    end
  end

  assign out_ok           = out_ok_r;
  assign out_popped_value = out_pop_r;
  assign out_count        = out_cnt_r;

endmodule
`default_nettype wire

// File: design/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring of DEPTH slots
// ----------------------------------------------------------------------------
// each operation is accepted only in idle and then passes through capture, slot
// store access (single port, registered read) and result load; the result beat
//   goes valid from the load, which waits while an earlier result is unaccepted
// the result register lets a new operation start while a result waits
// reset clears front index, count and the sequencer; slots are not cleared
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);
  import deq_pkg::*;

  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_ch.opcode),
    .in_value         (in_ch.value),
    .out_ok           (out_ch.ok),
    .out_popped_value (out_ch.popped_value),
    .out_count        (out_ch.count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire

// File: test/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded double-ended queue
// ----------------------------------------------------------------------------
// A directed opening covers empty pops at both ends, extreme values, a fill to
// capacity with pushes on a full queue, and two pops. Random traffic follows in
// segments whose push/pop mix swings between filling and draining, so that the
// full and empty boundaries are crossed often. Operation beats go in bursts with
// random gaps; the result side stalls on its own rotating pattern. A scoreboard
// keeps its own ring, front index and fill count, and checks every result beat
// field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned RANDOM_OPS  = 1524;

  class deque_scoreboard;
    typedef struct {
      logic   ok;
      data_t  popped_value;
      count_t count;
    } deque_result_t;

    data_t           ring[DEPTH];
    int unsigned     front_idx;
    int unsigned     fill;
    deque_result_t   expected_q[$];
    int unsigned     errors;

    function new();
      front_idx = 0;
      fill      = 0;
      errors    = 0;
    endfunction

    function void note_op(opcode_t op, data_t val);
      deque_result_t res;
      int unsigned   pos;
      res.ok           = 1'b0;
      res.popped_value = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill < DEPTH) begin
            if (op == OP_PUSH_FRONT) begin
              front_idx = (front_idx + DEPTH - 1) % DEPTH;
              pos       = front_idx;
            end else begin
              pos = (front_idx + fill) % DEPTH;
            end
            ring[pos] = val;
            fill++;
            res.ok = 1'b1;
          end
        end
        default: begin
          if (fill > 0) begin
            if (op == OP_POP_FRONT) begin
              pos       = front_idx;
              front_idx = (front_idx + 1) % DEPTH;
            end else begin
              pos = (front_idx + fill - 1) % DEPTH;
            end
            res.popped_value = ring[pos];
            fill--;
            res.ok = 1'b1;
          end
        end
      endcase
      res.count = count_t'(fill);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic ok, data_t popped_value, count_t cnt);
      deque_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, got ok %0b value %0d count %0d",
                 $time, ok, popped_value, cnt);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (ok !== exp_res.ok) begin
        $display("%0t: ok mismatch, expected %0b, got %0b", $time, exp_res.ok, ok);
        errors++;
      end
      if (popped_value !== exp_res.popped_value) begin
        $display("%0t: popped value mismatch, expected %0d, got %0d",
                 $time, exp_res.popped_value, popped_value);
        errors++;
      end
      if (cnt !== exp_res.count) begin
        $display("%0t: count mismatch, expected %0d, got %0d", $time, exp_res.count, cnt);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_ch();
  deq_out_if out_ch();

  deque_scoreboard queue_model;
  int unsigned     burst_left;
  int unsigned     rx_cycle = 0;

  double_ended_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // result side: rotating stall pattern
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      queue_model.check_result(out_ch.ok, out_ch.popped_value, out_ch.count);
    end
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 256) % 4)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 99) < 60);
      2:       out_ch.ready <= ((rx_cycle % 5) == 0);
      default: out_ch.ready <= (((rx_cycle / 9) % 2) == 0);
    endcase
  end

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic drive_op(opcode_t op, data_t val);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    queue_model.note_op(op, val);
    pace_sender();
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return data_t'($urandom);
    endcase
  endfunction

  initial begin
    opcode_t     op;
    int unsigned push_pct;
    queue_model = new();
    burst_left  = 1;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_PUSH_FRONT;
    in_ch.value  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops at both ends
    drive_op(OP_POP_FRONT, 32'sd5);
    drive_op(OP_POP_BACK, -32'sd5);
    // extreme values through both ends
    drive_op(OP_PUSH_FRONT, 32'sh8000_0000);
    drive_op(OP_PUSH_BACK, 32'sh7fff_ffff);
    drive_op(OP_POP_FRONT, '0);
    drive_op(OP_POP_BACK, '0);
    // fill to capacity from both ends, front index wraps
    for (int i = 0; i < DEPTH; i++) begin
      drive_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
               (i == 0) ? data_t'(0) : (i == 1) ? data_t'(-1) : data_t'($urandom));
    end
    // pushes on a full queue are dropped
    drive_op(OP_PUSH_FRONT, 32'sh7fff_ffff);
    drive_op(OP_PUSH_BACK, 32'sh8000_0000);
    drive_op(OP_POP_BACK, '0);
    drive_op(OP_POP_FRONT, '0);

    push_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 15;
          1:       push_pct = 35;
          2:       push_pct = 50;
          3:       push_pct = 65;
          default: push_pct = 85;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      drive_op(op, pick_value());
    end

    in_ch.valid <= 1'b0;
    while (queue_model.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (queue_model.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
design/deq_pkg.sv
design/deq_if.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue.sv
test/tb_double_ended_queue.sv
